[hw/rtl/midi_track_event_parser_unit_assert.svh]
// assertion macros for the track event parser
// both forms sample on aclk and are off while aresetn is low
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// condition implies property in the same cycle
`define MTEP_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("mtep: same-cycle check failed");

// condition implies property in the next cycle
`define MTEP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("mtep: next-cycle check failed");

`endif

[hw/rtl/mtep_pkg.sv]
`timescale 1ns / 1ps

package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_DATA1      = 4'd2,
        PH_DATA2      = 4'd3,
        PH_META_TYPE  = 4'd4,
        PH_META_LEN   = 4'd5,
        PH_META_BODY  = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SYSEX_BODY = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_OFF   = 3'd0,
        KIND_ON    = 3'd1,
        KIND_TEMPO = 3'd2,
        KIND_END   = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    localparam int VCNT_W  = 3;
    localparam int TICK_W  = 32;
    localparam int TEMPO_W = 24;

    localparam logic [7:0] META_END      = 8'h2f;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] STAT_META     = 8'hff;
    localparam logic [7:0] STAT_SYSEX    = 8'hf0;
    localparam logic [7:0] STAT_ESCAPE   = 8'hf7;
    localparam logic [7:0] STAT_SYSTEM   = 8'hf0;
    localparam logic [7:0] STAT_NOTE_OFF = 8'h80;
    localparam logic [7:0] STAT_NOTE_ON  = 8'h90;
    localparam logic [7:0] STAT_PROGRAM  = 8'hc0;
    localparam logic [7:0] STAT_PRESSURE = 8'hd0;

    typedef struct packed {
        phase_t              phase;
        logic [7:0]          running_status;
        logic [7:0]          current_status;
        logic [VCNT_W-1:0]   var_count;
        logic [TICK_W-1:0]   abs_tick;
        logic [7:0]          meta_type;
        logic [7:0]          first_data;
        logic [TEMPO_W-1:0]  tempo_collect;
        logic                halted;
    } parse_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [3:0]          channel;
        logic [7:0]          note;
        logic [7:0]          velocity;
        logic [TEMPO_W-1:0]  tempo;
        logic [TICK_W-1:0]   tick;
    } event_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_DELTA,
        running_status: 8'h00,
        current_status: 8'h00,
        var_count:      {VCNT_W{1'b0}},
        abs_tick:       {TICK_W{1'b0}},
        meta_type:      8'h00,
        first_data:     8'h00,
        tempo_collect:  {TEMPO_W{1'b0}},
        halted:         1'b0
    };

endpackage

[hw/rtl/mtep_decode.sv]
`timescale 1ns / 1ps

module mtep_decode #(
    parameter int MAX_VAR_BYTES = 4
) (
    input  logic [7:0]                   byte_in,
    input  logic                         track_start,
    input  logic                         track_end,
    input  mtep_pkg::parse_state_t       state_in,
    input  logic [7*MAX_VAR_BYTES-1:0]   var_in,
    input  logic [7*MAX_VAR_BYTES-1:0]   skip_in,
    output mtep_pkg::parse_state_t       state_out,
    output logic [7*MAX_VAR_BYTES-1:0]   var_out,
    output logic [7*MAX_VAR_BYTES-1:0]   skip_out,
    output logic                         ev_valid,
    output mtep_pkg::event_t             ev
);

    localparam int VAR_W     = 7 * MAX_VAR_BYTES;
    localparam int CNT_INC_W = mtep_pkg::VCNT_W + 1;
    localparam int SUM_W     = ((VAR_W > mtep_pkg::TICK_W) ? VAR_W : mtep_pkg::TICK_W) + 1;

    mtep_pkg::parse_state_t  cur;
    mtep_pkg::parse_state_t  nxt;
    logic [VAR_W-1:0]        cur_var;
    logic [VAR_W-1:0]        cur_skip;
    logic [VAR_W+6:0]        var_cat;
    logic [VAR_W-1:0]        var_take;
    logic [VAR_W-1:0]        skip_dec;
    logic [CNT_INC_W-1:0]    cnt_inc;
    logic                    var_more;
    logic                    var_err;
    logic [SUM_W-1:0]        tick_sum;
    logic                    tick_ovf;
    logic                    fail;
    logic                    meta_done;
    logic                    var_clear;

    function automatic logic is_short_msg(input logic [7:0] status);
        return (status[7:4] == mtep_pkg::STAT_PROGRAM[7:4]) ||
               (status[7:4] == mtep_pkg::STAT_PRESSURE[7:4]);
    endfunction

    // track start restarts the parse before the byte is looked at
    assign cur      = track_start ? mtep_pkg::STATE_RESET : state_in;
    assign cur_var  = track_start ? {VAR_W{1'b0}} : var_in;
    assign cur_skip = track_start ? {VAR_W{1'b0}} : skip_in;

    assign var_cat  = {cur_var, byte_in[6:0]};
    assign var_take = var_cat[VAR_W-1:0];
    assign skip_dec = cur_skip - VAR_W'(1);
    assign cnt_inc  = {1'b0, cur.var_count} + CNT_INC_W'(1);
    assign var_more = byte_in[7];
    assign var_err  = byte_in[7] && (cnt_inc >= CNT_INC_W'(MAX_VAR_BYTES));
    assign tick_sum = SUM_W'(cur.abs_tick) + SUM_W'(var_take);
    assign tick_ovf = |tick_sum[SUM_W-1:mtep_pkg::TICK_W];

    always_comb begin
        nxt         = cur;
        var_out     = cur_var;
        skip_out    = cur_skip;
        ev_valid    = 1'b0;
        ev          = '0;
        fail        = 1'b0;
        meta_done   = 1'b0;
        var_clear   = 1'b0;

        if (!cur.halted) begin
            case (cur.phase)
                mtep_pkg::PH_DELTA: begin
                    var_out = var_take;
                    if (var_err) begin
                        fail = 1'b1;
                    end else if (var_more) begin
                        nxt.var_count = cnt_inc[mtep_pkg::VCNT_W-1:0];
                    end else begin
                        nxt.var_count = '0;
                        if (tick_ovf) begin
                            fail = 1'b1;
                        end else begin
                            nxt.abs_tick = tick_sum[mtep_pkg::TICK_W-1:0];
                            nxt.phase    = mtep_pkg::PH_STATUS;
                        end
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    if (!byte_in[7]) begin
                        // running status: this byte is already the first data byte
                        if (!cur.running_status[7] ||
                            cur.running_status >= mtep_pkg::STAT_SYSTEM) begin
                            fail = 1'b1;
                        end else begin
                            nxt.current_status = cur.running_status;
                            nxt.first_data     = byte_in;
                            if (is_short_msg(cur.running_status)) begin
                                nxt.phase = mtep_pkg::PH_DELTA;
                                var_clear = 1'b1;
                            end else begin
                                nxt.phase = mtep_pkg::PH_DATA2;
                            end
                        end
                    end else if (byte_in == mtep_pkg::STAT_META) begin
                        nxt.phase = mtep_pkg::PH_META_TYPE;
                    end else if (byte_in == mtep_pkg::STAT_SYSEX ||
                                 byte_in == mtep_pkg::STAT_ESCAPE) begin
                        var_clear = 1'b1;
                        nxt.phase = mtep_pkg::PH_SYSEX_LEN;
                    end else if (byte_in >= mtep_pkg::STAT_SYSTEM) begin
                        fail = 1'b1;
                    end else begin
                        nxt.running_status = byte_in;
                        nxt.current_status = byte_in;
                        nxt.phase          = mtep_pkg::PH_DATA1;
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    nxt.first_data = byte_in;
                    if (is_short_msg(cur.current_status)) begin
                        nxt.phase = mtep_pkg::PH_DELTA;
                        var_clear = 1'b1;
                    end else begin
                        nxt.phase = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    nxt.phase = mtep_pkg::PH_DELTA;
                    var_clear = 1'b1;
                    if (cur.current_status[7:4] == mtep_pkg::STAT_NOTE_ON[7:4] &&
                        byte_in != 8'h00) begin
                        ev_valid = 1'b1;
                        ev.kind  = mtep_pkg::KIND_ON;
                    end else if (cur.current_status[7:4] == mtep_pkg::STAT_NOTE_ON[7:4] ||
                                 cur.current_status[7:4] == mtep_pkg::STAT_NOTE_OFF[7:4]) begin
                        ev_valid = 1'b1;
                        ev.kind  = mtep_pkg::KIND_OFF;
                    end
                    ev.channel  = cur.current_status[3:0];
                    ev.note     = cur.first_data;
                    ev.velocity = byte_in;
                end
                mtep_pkg::PH_META_TYPE: begin
                    nxt.meta_type = byte_in;
                    var_clear     = 1'b1;
                    nxt.phase     = mtep_pkg::PH_META_LEN;
                end
                mtep_pkg::PH_META_LEN: begin
                    var_out = var_take;
                    if (var_err) begin
                        fail = 1'b1;
                    end else if (var_more) begin
                        nxt.var_count = cnt_inc[mtep_pkg::VCNT_W-1:0];
                    end else begin
                        nxt.var_count     = '0;
                        skip_out          = var_take;
                        nxt.tempo_collect = '0;
                        // a tempo meta of the wrong length is skipped as a plain meta
                        if (cur.meta_type == mtep_pkg::META_TEMPO && var_take != VAR_W'(3)) begin
                            nxt.meta_type = 8'h00;
                        end
                        if (var_take == '0) begin
                            meta_done = 1'b1;
                        end else begin
                            nxt.phase = mtep_pkg::PH_META_BODY;
                        end
                    end
                end
                mtep_pkg::PH_META_BODY: begin
                    nxt.tempo_collect = {cur.tempo_collect[mtep_pkg::TEMPO_W-9:0], byte_in};
                    skip_out          = skip_dec;
                    if (skip_dec == '0) begin
                        meta_done = 1'b1;
                    end
                end
                mtep_pkg::PH_SYSEX_LEN: begin
                    var_out = var_take;
                    if (var_err) begin
                        fail = 1'b1;
                    end else if (var_more) begin
                        nxt.var_count = cnt_inc[mtep_pkg::VCNT_W-1:0];
                    end else begin
                        nxt.var_count = '0;
                        skip_out      = var_take;
                        if (var_take == '0) begin
                            nxt.phase = mtep_pkg::PH_DELTA;
                            var_clear = 1'b1;
                        end else begin
                            nxt.phase = mtep_pkg::PH_SYSEX_BODY;
                        end
                    end
                end
                mtep_pkg::PH_SYSEX_BODY: begin
                    skip_out = skip_dec;
                    if (skip_dec == '0) begin
                        nxt.phase = mtep_pkg::PH_DELTA;
                        var_clear = 1'b1;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase

            if (meta_done) begin
                nxt.phase = mtep_pkg::PH_DELTA;
                var_clear = 1'b1;
                if (nxt.meta_type == mtep_pkg::META_END) begin
                    ev_valid   = 1'b1;
                    ev.kind    = mtep_pkg::KIND_END;
                    nxt.halted = 1'b1;
                end else if (nxt.meta_type == mtep_pkg::META_TEMPO) begin
                    ev_valid = 1'b1;
                    ev.kind  = mtep_pkg::KIND_TEMPO;
                    ev.tempo = nxt.tempo_collect;
                end
            end

            if (var_clear) begin
                var_out       = '0;
                nxt.var_count = '0;
            end

            // the last byte of a track must close the event in progress
            if (track_end) begin
                if (!fail && !ev_valid &&
                    (nxt.phase != mtep_pkg::PH_DELTA || nxt.var_count != '0)) begin
                    fail = 1'b1;
                end
                nxt.halted = 1'b1;
            end

            if (fail) begin
                nxt.halted = 1'b1;
                ev_valid   = 1'b1;
                ev         = '0;
                ev.kind    = mtep_pkg::KIND_ERROR;
            end
        end

        ev.tick   = nxt.abs_tick;
        state_out = nxt;
    end

endmodule

[hw/rtl/midi_track_event_parser_unit.sv]
`timescale 1ns / 1ps
// channel  direction  transaction                        sideband
// s_       in         one byte of a track chunk body     tlast = last byte, tuser = first byte
// m_       out        one parsed event                   tuser = event kind
//
// one byte is taken every cycle while s_tready is high; the parse state and the event
// are settled in the same cycle by the decoder and captured in the state and result
// registers. a byte that yields an event is taken as fast as a byte that yields none.
// s_tready drops only while the result register is full and m_tready is low.
// aresetn clears the parse state and the result valid flag.

`include "midi_track_event_parser_unit_assert.svh"

module midi_track_event_parser_unit #(
    parameter int MAX_VAR_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tlast,   // track_end
    input  logic        s_tuser,   // track_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // channel [3:0], note [11:4], velocity [19:12],
                                   // tempo [43:20], tick [75:44], zero [79:76]
    output logic [2:0]  m_tuser    // event_kind [2:0]
);

    localparam int VAR_W = 7 * MAX_VAR_BYTES;

    mtep_pkg::parse_state_t  state_reg;
    mtep_pkg::parse_state_t  state_next;
    logic [VAR_W-1:0]        var_reg;
    logic [VAR_W-1:0]        var_next;
    logic [VAR_W-1:0]        skip_reg;
    logic [VAR_W-1:0]        skip_next;
    logic                    ev_valid;
    mtep_pkg::event_t        ev;
    logic                    s_acc;
    logic                    m_tvalid_reg;
    mtep_pkg::event_t        out_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    mtep_decode #(
        .MAX_VAR_BYTES (MAX_VAR_BYTES)
    ) u_decode (
        .byte_in     (s_tdata),
        .track_start (s_tuser),
        .track_end   (s_tlast),
        .state_in    (state_reg),
        .var_in      (var_reg),
        .skip_in     (skip_reg),
        .state_out   (state_next),
        .var_out     (var_next),
        .skip_out    (skip_next),
        .ev_valid    (ev_valid),
        .ev          (ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mtep_pkg::STATE_RESET;
            var_reg      <= '0;
            skip_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                state_reg <= state_next;
                var_reg   <= var_next;
                skip_reg  <= skip_next;
            end
            if (s_acc && ev_valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && ev_valid) begin
            out_reg <= ev;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'b0000, out_reg.tick, out_reg.tempo, out_reg.velocity,
                       out_reg.note, out_reg.channel};

    // a full result register must hold off the input side
    `MTEP_ASSERT_NOW(a_no_overrun, m_tvalid_reg && !m_tready, !s_tready)
    // an event from an accepted byte shows up on the next cycle
    `MTEP_ASSERT_NEXT(a_event_lands, s_acc && ev_valid, m_tvalid_reg)
    // a halted parser stays silent until the next track start
    `MTEP_ASSERT_NOW(a_halt_silent, s_acc && state_reg.halted && !s_tuser, !ev_valid)
    // the last byte of a track always leaves the parser halted
    `MTEP_ASSERT_NEXT(a_last_halts, s_acc && s_tlast, state_reg.halted)

endmodule
